/* src/masked_packed_integer_alu_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the masked packed integer ALU
// Shorthand for clocked implications, checked only while out of reset.
// ----------------------------------------------------------------------------
`ifndef MASKED_PACKED_INTEGER_ALU_UNIT_MACROS_SVH
`define MASKED_PACKED_INTEGER_ALU_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPIA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define MPIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

/* src/mpia_pkg.sv */
// ----------------------------------------------------------------------------
// mpia_pkg
// Types and constants shared by the masked packed integer ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpia_pkg;

  localparam int DATA_W      = 64;
  localparam int BYTES       = 8;
  localparam int IN_TDATA_W  = 256;
  localparam int IN_TUSER_W  = 10;
  localparam int OUT_TDATA_W = 64;

  typedef enum logic [2:0] {
    OP_XOR = 3'd0,
    OP_AND = 3'd1,
    OP_OR  = 3'd2,
    OP_ADD = 3'd3,
    OP_SUB = 3'd4,
    OP_MOV = 3'd5
  } op_t;

  // Bytes that open a new lane, indexed by the lane size code
  // (byte, word, dword, qword).
  localparam logic [7:0] LANE_START [0:3] = '{8'hFF, 8'h55, 8'h11, 8'h01};

endpackage

/* src/masked_packed_integer_alu_unit.sv */
// ----------------------------------------------------------------------------
// masked_packed_integer_alu_unit
// Throughput: one word per cycle unless out_tready stalls the output; three
// register stages (lane mask decode, lane-segmented ALU, merge and output
// register) share one stall enable, and a word passes them in that order.
// Reset: synchronous, active low; it clears the stage valid bits only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "masked_packed_integer_alu_unit_macros.svh"

module masked_packed_integer_alu_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // Low to high: vector mask, first_operand, second_operand, old_destination.
  input  logic [mpia_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Low to high: op, lane_size_code, masking_on, zeroing, chunk_index.
  input  logic [mpia_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // result_slice.
  output logic [mpia_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int W = mpia_pkg::DATA_W;
  localparam int B = mpia_pkg::BYTES;

  logic                 adv;

  // Input fields.
  logic [2:0]           in_op;
  logic [1:0]           in_code;
  logic                 in_masking;
  logic                 in_zero;
  logic [2:0]           in_chunk;
  logic [W-1:0]         in_mask;

  // Stage 1: per-byte activity and operands.
  logic                 s1_valid_r;
  mpia_pkg::op_t        s1_op_r;
  logic [1:0]           s1_code_r;
  logic                 s1_zero_r;
  logic [B-1:0]         s1_act_r, s1_act_nxt;
  logic [W-1:0]         s1_a_r, s1_b_r, s1_old_r;

  // Stage 2: lane results.
  logic                 s2_valid_r;
  logic [W-1:0]         s2_res_r, s2_res_nxt;
  logic [B-1:0]         s2_act_r;
  logic                 s2_zero_r;
  logic [W-1:0]         s2_old_r;

  // Stage 3: merged output.
  logic                 out_valid_r;
  logic [W-1:0]         out_data_r, out_data_nxt;

  assign in_op      = in_tuser[2:0];
  assign in_code    = in_tuser[4:3];
  assign in_masking = in_tuser[5];
  assign in_zero    = in_tuser[6];
  assign in_chunk   = in_tuser[9:7];
  assign in_mask    = in_tdata[W-1:0];

  // The whole pipe moves when the output register is free or being drained.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // The vector lane index of byte j is {chunk, j} shifted right by the code,
  // since chunk * lanes is a multiple of the lane count.
  always_comb begin
    for (int j = 0; j < B; j++) begin
      logic [5:0] gidx;
      gidx = 6'({in_chunk, 3'(j)} >> in_code);
      s1_act_nxt[j] = !in_masking || in_mask[gidx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r   <= mpia_pkg::op_t'(in_op);
      s1_code_r <= in_code;
      s1_zero_r <= in_zero;
      s1_act_r  <= s1_act_nxt;
      s1_a_r    <= in_tdata[2*W-1:W];
      s1_b_r    <= in_tdata[3*W-1:2*W];
      s1_old_r  <= in_tdata[4*W-1:3*W];
    end
  end

  // Byte-sliced adder whose carry chain breaks at every lane start;
  // subtract adds the inverted operand with a carry-in of one per lane.
  always_comb begin
    logic         sub;
    logic         carry;
    logic [7:0]   bx;
    logic [8:0]   bsum;
    logic [W-1:0] sum;
    logic [7:0]   starts;
    sub    = (s1_op_r == mpia_pkg::OP_SUB);
    starts = mpia_pkg::LANE_START[s1_code_r];
    carry  = 1'b0;
    sum    = '0;
    for (int j = 0; j < B; j++) begin
      bx    = sub ? ~s1_b_r[j*8 +: 8] : s1_b_r[j*8 +: 8];
      bsum  = {1'b0, s1_a_r[j*8 +: 8]} + {1'b0, bx} + {8'd0, (starts[j] ? sub : carry)};
      carry = bsum[8];
      sum[j*8 +: 8] = bsum[7:0];
    end
    case (s1_op_r)
      mpia_pkg::OP_XOR: s2_res_nxt = s1_a_r ^ s1_b_r;
      mpia_pkg::OP_AND: s2_res_nxt = s1_a_r & s1_b_r;
      mpia_pkg::OP_OR:  s2_res_nxt = s1_a_r | s1_b_r;
      mpia_pkg::OP_ADD: s2_res_nxt = sum;
      mpia_pkg::OP_SUB: s2_res_nxt = sum;
      mpia_pkg::OP_MOV: s2_res_nxt = s1_b_r;
      default:          s2_res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_res_r  <= s2_res_nxt;
      s2_act_r  <= s1_act_r;
      s2_zero_r <= s1_zero_r;
      s2_old_r  <= s1_old_r;
    end
  end

  // Inactive bytes are zeroed or take the old destination.
  always_comb begin
    for (int j = 0; j < B; j++) begin
      if (s2_act_r[j]) begin
        out_data_nxt[j*8 +: 8] = s2_res_r[j*8 +: 8];
      end else if (s2_zero_r) begin
        out_data_nxt[j*8 +: 8] = 8'd0;
      end else begin
        out_data_nxt[j*8 +: 8] = s2_old_r[j*8 +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `MPIA_ASSERT_SAME(a_out_from_s2, clk, rst_n, $rose(out_tvalid), $past(s2_valid_r))
  `MPIA_ASSERT_NEXT(a_unmasked_all_active, clk, rst_n, in_tvalid && in_tready && !in_masking, s1_act_r == 8'hFF)
  `MPIA_ASSERT_NEXT(a_zeroing_all_off, clk, rst_n, adv && s2_valid_r && s2_zero_r && s2_act_r == 8'h00, out_tdata == 64'd0)

endmodule
